@@ hw/rtl/f32mul_pkg.sv @@
// Package for the single-precision truncating multiplier.
// Holds the binary32 field widths and the special result codes; no dependencies.
package f32mul_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned EXP_W = 8;
    localparam int unsigned SIG_W = FRAC_W + 1;
    localparam int unsigned PROD_W = 2 * SIG_W;
    localparam int unsigned EXPI_W = 11;

    localparam logic [EXP_W-1:0] EXP_MAX = 8'hFF;
    localparam logic [WORD_W-1:0] DEFAULT_NAN = 32'h7FC0_0001;

endpackage

@@ hw/rtl/float32_multiply_truncating_unit.sv @@
// Top level of the single-precision truncating multiplier.
// Two register stages, operand and result, with the arithmetic between them; uses f32mul_pkg.
//
//  Channel   Direction  Handshake            Word
//  input     in         in_valid / in_stall  operand_a, operand_b
//  output    out        out_valid/out_stall  product
//
// A word accepted into the operand register is multiplied, normalized and packed combinationally
// and is written to the result register once that register is empty or its output is not stalled.
// One word is accepted in every cycle while the output is not stalled.
// Reset clears the valid flags only; a stall holds each full register in place.
module float32_multiply_truncating_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] product
);

    localparam int unsigned FW = f32mul_pkg::FRAC_W;
    localparam int unsigned EW = f32mul_pkg::EXP_W;
    localparam int unsigned SW = f32mul_pkg::SIG_W;
    localparam int unsigned PW = f32mul_pkg::PROD_W;
    localparam int unsigned IW = f32mul_pkg::EXPI_W;

    logic        s1_valid_reg;
    logic [31:0] s1_a_reg;
    logic [31:0] s1_b_reg;
    logic        out_valid_reg;
    logic [31:0] product_reg;

    logic en1;
    logic en2;

    assign en2 = !out_valid_reg || !out_stall;
    assign en1 = !s1_valid_reg || en2;
    assign in_stall = !en1;
    assign out_valid = out_valid_reg;
    assign product = product_reg;

    // Classification, exponent sum and significand product.
    logic [EW-1:0] ea;
    logic [EW-1:0] eb;
    logic [FW-1:0] fa;
    logic [FW-1:0] fb;
    logic sign1;
    logic nan_a;
    logic nan_b;
    logic snan_a;
    logic snan_b;
    logic inf_a;
    logic inf_b;
    logic zero_a;
    logic zero_b;
    logic special1;
    logic [31:0] value1;
    logic signed [IW-1:0] e1;
    logic signed [IW-1:0] e1_adj;
    logic [SW-1:0] ma;
    logic [SW-1:0] mb;
    logic [PW-1:0] prod1;

    always_comb
    begin
        ea = s1_a_reg[30:23];
        eb = s1_b_reg[30:23];
        fa = s1_a_reg[FW-1:0];
        fb = s1_b_reg[FW-1:0];
        sign1 = s1_a_reg[31] ^ s1_b_reg[31];
        nan_a = (ea == f32mul_pkg::EXP_MAX) && (fa != '0);
        nan_b = (eb == f32mul_pkg::EXP_MAX) && (fb != '0);
        snan_a = nan_a && !fa[FW-1];
        snan_b = nan_b && !fb[FW-1];
        inf_a = (ea == f32mul_pkg::EXP_MAX) && (fa == '0);
        inf_b = (eb == f32mul_pkg::EXP_MAX) && (fb == '0);
        zero_a = (ea == '0) && (fa == '0);
        zero_b = (eb == '0) && (fb == '0);
        e1 = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
        special1 = 1'b1;
        if (nan_a || nan_b)
        begin
            if (snan_a)
                value1 = {sign1, s1_a_reg[30:0]};
            else if (snan_b)
                value1 = {sign1, s1_b_reg[30:0]};
            else
                value1 = f32mul_pkg::DEFAULT_NAN;
        end
        else if (inf_a || inf_b)
        begin
            if (zero_a || zero_b)
                value1 = f32mul_pkg::DEFAULT_NAN;
            else
                value1 = {sign1, f32mul_pkg::EXP_MAX, {FW{1'b0}}};
        end
        else if (zero_a || zero_b)
            value1 = {sign1, 31'b0};
        else if (e1 >= 11'sd255)
            value1 = {sign1, f32mul_pkg::EXP_MAX, {FW{1'b0}}};
        else if (e1 < 11'sd0)
            value1 = {sign1, 31'b0};
        else
        begin
            special1 = 1'b0;
            value1 = {sign1, 31'b0};
        end
        e1_adj = e1 + $signed({{(IW-1){1'b0}}, (ea == '0)})
                    + $signed({{(IW-1){1'b0}}, (eb == '0)});
        ma = {(ea != '0), fa};
        mb = {(eb != '0), fb};
        prod1 = PW'(ma) * PW'(mb);
    end

    // Normalization, overflow, subnormal shift and packing.
    logic [5:0] msb;
    logic [5:0] sh_norm;
    logic [PW-1:0] p_norm;
    logic signed [IW-1:0] e2;
    logic signed [IW-1:0] sh_sub;
    logic [SW-1:0] p_sub;
    logic [31:0] value2;

    always_comb
    begin
        msb = '0;
        p_sub = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (prod1[i])
                msb = 6'(i);
        end
        sh_norm = (msb > 6'(FW)) ? (msb - 6'(FW)) : 6'd0;
        p_norm = prod1 >> sh_norm;
        e2 = e1_adj + $signed({5'b0, sh_norm}) - 11'sd23;
        sh_sub = 11'sd1 - e2;
        if (special1)
            value2 = value1;
        else if (e2 >= 11'sd255)
            value2 = {sign1, f32mul_pkg::EXP_MAX, {FW{1'b0}}};
        else if (e2 <= 11'sd0)
        begin
            if (sh_sub < 11'sd32)
                p_sub = p_norm[SW-1:0] >> sh_sub[4:0];
            value2 = {sign1, 8'h00, p_sub[FW-1:0]};
        end
        else
            value2 = {sign1, e2[EW-1:0], p_norm[FW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_a_reg <= operand_a;
            s1_b_reg <= operand_b;
        end
        if (en2 && s1_valid_reg)
            product_reg <= value2;
    end

    a_empty_output_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while the output register is empty");

    a_operand_hold_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en1) |-> (out_valid_reg && out_stall))
        else $error("operand register held without a blocked output");

    a_result_stable_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(product_reg)))
        else $error("stalled result word changed");

endmodule

@@ sim/float32_multiply_truncating_unit_checker.sv @@
// Checker for the single-precision truncating multiplier: watches both channels,
// predicts each product from the accepted operands and compares. Uses f32mul_pkg.
module float32_multiply_truncating_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] product,
    output int          errors,
    output int          pending,
    output int          checked
);

    logic [31:0] expected_products[$];

    function automatic logic [31:0] truncated_product(logic [31:0] a, logic [31:0] b);
        logic [31:0] sgn;
        logic [7:0] ea;
        logic [7:0] eb;
        logic [63:0] p;
        int e;
        int sh;
        bit a_nan;
        bit b_nan;
        bit a_inf;
        bit b_inf;
        bit a_zero;
        bit b_zero;
        sgn = (a ^ b) & 32'h8000_0000;
        ea = a[30:23];
        eb = b[30:23];
        a_nan = (ea == f32mul_pkg::EXP_MAX) && (a[22:0] != 0);
        b_nan = (eb == f32mul_pkg::EXP_MAX) && (b[22:0] != 0);
        a_inf = (ea == f32mul_pkg::EXP_MAX) && (a[22:0] == 0);
        b_inf = (eb == f32mul_pkg::EXP_MAX) && (b[22:0] == 0);
        a_zero = (ea == 0) && (a[22:0] == 0);
        b_zero = (eb == 0) && (b[22:0] == 0);
        if (a_nan || b_nan)
        begin
            if (a_nan && !a[22])
                return sgn | {1'b0, a[30:0]};
            if (b_nan && !b[22])
                return sgn | {1'b0, b[30:0]};
            return f32mul_pkg::DEFAULT_NAN;
        end
        if (a_inf || b_inf)
        begin
            if (a_zero || b_zero)
                return f32mul_pkg::DEFAULT_NAN;
            return sgn | {1'b0, f32mul_pkg::EXP_MAX, 23'd0};
        end
        if (a_zero || b_zero)
            return sgn;
        e = int'(ea) + int'(eb) - 127;
        if (e >= 255)
            return sgn | {1'b0, f32mul_pkg::EXP_MAX, 23'd0};
        if (e < 0)
            return sgn;
        if (ea == 0)
            e++;
        if (eb == 0)
            e++;
        p = {40'd0, ea != 0, a[22:0]} * {40'd0, eb != 0, b[22:0]};
        while (p >= 64'd1 << 24)
        begin
            p >>= 1;
            e++;
        end
        e -= 23;
        if (e >= 255)
            return sgn | {1'b0, f32mul_pkg::EXP_MAX, 23'd0};
        if (e <= 0)
        begin
            sh = 1 - e;
            p = (sh >= 32) ? 64'd0 : p >> sh;
            if (p == 0)
                return sgn;
            return sgn | {9'd0, p[22:0]};
        end
        return sgn | {1'b0, e[7:0], p[22:0]};
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    assign pending = expected_products.size();

    initial
    begin
        errors = 0;
        checked = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_products.push_back(truncated_product(operand_a, operand_b));
            if (out_valid && !out_stall)
            begin
                if (expected_products.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", product));
                else
                begin
                    if (product !== expected_products[0])
                        report_mismatch($sformatf("product %h, expected %h",
                                                  product, expected_products[0]));
                    void'(expected_products.pop_front());
                    checked++;
                end
            end
        end
    end

endmodule

@@ sim/float32_multiply_truncating_unit_test.sv @@
// Testbench top for the single-precision truncating multiplier: drives directed
// and random operand pairs with random idling. Needs the block, the checker and f32mul_pkg.
module float32_multiply_truncating_unit_test;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic out_valid;
    logic out_stall;
    logic [31:0] product;
    int errors;
    int pending;
    int checked;
    bit quiet_stretch;
    int sent;

    float32_multiply_truncating_unit dut (.*);

    float32_multiply_truncating_unit_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] pick_operand();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0: w[30:23] = 8'hFF;
            1: w[30:23] = 8'h00;
            2: w[30:23] = 8'(63 + $urandom_range(0, 130));
            3: w[22:0] = ($urandom_range(0, 1) != 0) ? 23'd0 : 23'h7FFFFF;
            default: w[30:23] = 8'(100 + $urandom_range(0, 54));
        endcase
        return w;
    endfunction

    task automatic send_word(logic [31:0] a, logic [31:0] b);
        while (!quiet_stretch && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    always @(posedge clk)
        out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 30);

    initial
    begin
        #20_000_000;
        $display("float32_multiply_truncating_unit test failed");
        $finish;
    end

    initial
    begin
        logic [31:0] corner[16];
        int drain;
        corner = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'hFFBF_FFFF,
                   32'h3F80_0000, 32'hBFFF_FFFF, 32'h0000_0001, 32'h007F_FFFF,
                   32'h0080_0000, 32'h7F7F_FFFF, 32'h2000_0000, 32'h5F80_0000};
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        operand_a = '0;
        operand_b = '0;
        quiet_stretch = 1'b0;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 5; i++)
            send_word(corner[$urandom_range(0, 15)], corner[$urandom_range(0, 15)]);
        foreach (corner[i])
            send_word(corner[i], corner[15 - i]);
        send_word(32'h7F80_0001, 32'h7FC0_0000);
        send_word(32'h7FC0_0000, 32'hFF80_0005);
        send_word(32'h3F00_0000, 32'h0080_0000);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < 1250; i++)
        begin
            quiet_stretch = (i >= 400 && i < 600);
            send_word(pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;
        quiet_stretch = 1'b0;
        @(posedge clk);
        drain = 0;
        while (pending != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        $display("Sent %0d operand pairs, corner cases and random, and checked %0d products.",
                 sent, checked);
        if (errors == 0 && pending == 0)
            $display("float32_multiply_truncating_unit test passed");
        else
            $display("float32_multiply_truncating_unit test failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/f32mul_pkg.sv
hw/rtl/float32_multiply_truncating_unit.sv
sim/float32_multiply_truncating_unit_checker.sv
sim/float32_multiply_truncating_unit_test.sv
